[sv/wmpc_pkg.sv]
// ----------------------------------------------------------------------------
// wmpc_pkg - shared definitions of the windowed median power convergence unit
// Defaults of the top-level parameters, register indexes, sideband layout and
// the control group that starts a window update.
// ----------------------------------------------------------------------------
`default_nettype none

package wmpc_pkg;

	localparam int WINDOW_DEPTH_DEF = 16;
	localparam int POWER_WIDTH_DEF  = 24;

	// min_fill register
	localparam int               MIN_FILL_W     = 4;
	localparam logic [MIN_FILL_W-1:0] MIN_FILL_RESET = 4'd15;

	// configuration register indexes
	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_MIN_BUDGET = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_BUDGET = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_MIN_FILL   = 2'd2;

	// input tuser bits
	localparam int IN_USER_W     = 2;
	localparam int IN_BUDGET_VLD = 0;
	localparam int IN_SAMPLE_VLD = 1;

	// output tuser bits
	localparam int OUT_USER_W    = 3;
	localparam int OUT_WRITE_LIM = 0;
	localparam int OUT_REPORT    = 1;
	localparam int OUT_CONVERGED = 2;

	// start of one sorted-window update
	typedef struct packed {
		logic start;   // one-cycle pulse
		logic remove;  // window full: drop the oldest value from the sorted copy
	} wmpc_sort_ctrl_t;

endpackage

`default_nettype wire

[sv/wmpc_budget.sv]
// ----------------------------------------------------------------------------
// wmpc_budget - budget clamp and stored budget
// Holds the budget bounds, clamps a requested budget and tracks the stored one.
// ----------------------------------------------------------------------------
`default_nettype none

module wmpc_budget #(
	parameter int POWER_WIDTH = wmpc_pkg::POWER_WIDTH_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_we,
	input  wire [wmpc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire [POWER_WIDTH-1:0]             cfg_data,
	input  wire                               update,
	input  wire                               budget_valid,
	input  wire [POWER_WIDTH-1:0]             budget_value,
	output logic                              write_limit,
	output logic [POWER_WIDTH-1:0]            limit_value,
	output logic [POWER_WIDTH-1:0]            stored_budget,
	output logic                              budget_known
);

	logic [POWER_WIDTH-1:0] min_budget_q;
	logic [POWER_WIDTH-1:0] max_budget_q;
	logic [POWER_WIDTH-1:0] stored_q;
	logic                   known_q;
	logic [POWER_WIDTH-1:0] clamped;
	logic                   change;

	always_comb begin
		if (budget_value < min_budget_q) begin
			clamped = min_budget_q;
		end else if (budget_value > max_budget_q) begin
			clamped = max_budget_q;
		end else begin
			clamped = budget_value;
		end
		change      = budget_valid && (!known_q || (stored_q != clamped));
		write_limit = change;
		limit_value = change ? clamped : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_budget_q <= '0;
			max_budget_q <= '1;
			stored_q     <= '0;
			known_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					wmpc_pkg::CFG_MIN_BUDGET: min_budget_q <= cfg_data;
					wmpc_pkg::CFG_MAX_BUDGET: max_budget_q <= cfg_data;
					default: ;
				endcase
			end
			if (update) begin
				stored_q <= budget_valid ? clamped : '0;
				known_q  <= budget_valid;
			end
		end
	end

	assign stored_budget = stored_q;
	assign budget_known  = known_q;

endmodule

`default_nettype wire

[sv/wmpc_ring.sv]
// ----------------------------------------------------------------------------
// wmpc_ring - arrival-order sample ring
// Writes each sample at the write pointer and returns the entry it replaces.
// ----------------------------------------------------------------------------
`default_nettype none

module wmpc_ring #(
	parameter int WINDOW_DEPTH = wmpc_pkg::WINDOW_DEPTH_DEF,
	parameter int POWER_WIDTH  = wmpc_pkg::POWER_WIDTH_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    wr_en,
	input  wire [POWER_WIDTH-1:0]  wr_data,
	output logic [POWER_WIDTH-1:0] old_data
);

	localparam int AW = $clog2(WINDOW_DEPTH);

	logic [POWER_WIDTH-1:0] mem [WINDOW_DEPTH];
	logic [AW-1:0]          wp_q;
	logic [POWER_WIDTH-1:0] rd_q;

	// read-first: the old entry comes out the cycle after the write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wp_q] <= wr_data;
		end
		rd_q <= mem[wp_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
		end else if (wr_en) begin
			wp_q <= (wp_q == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_q + 1'b1;
		end
	end

	assign old_data = rd_q;

endmodule

`default_nettype wire

[sv/wmpc_sorter.sv]
// ----------------------------------------------------------------------------
// wmpc_sorter - sorted copy of the window and median
// One merge pass over the sorted memory drops a full window's oldest value and
// bubbles in the new one; the median is the middle entry or middle pair mean.
// ----------------------------------------------------------------------------
`default_nettype none

module wmpc_sorter #(
	parameter int WINDOW_DEPTH = wmpc_pkg::WINDOW_DEPTH_DEF,
	parameter int POWER_WIDTH  = wmpc_pkg::POWER_WIDTH_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wmpc_pkg::wmpc_sort_ctrl_t       ctrl,
	input  wire [$clog2(WINDOW_DEPTH+1)-1:0] count,
	input  wire [POWER_WIDTH-1:0]           new_value,
	input  wire [POWER_WIDTH-1:0]           old_value,
	output logic                            done,
	output logic [POWER_WIDTH-1:0]          median
);

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int CW = $clog2(WINDOW_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PASS,
		ST_MED_HI,
		ST_MED_LO,
		ST_MED_SUM
	} state_t;

	state_t                 state_q;
	logic [CW-1:0]          n_q;
	logic [CW-1:0]          m_q;
	logic [CW-1:0]          rk_q;
	logic [CW-1:0]          wi_q;
	logic [POWER_WIDTH-1:0] carry_q;
	logic [POWER_WIDTH-1:0] old_q;
	logic                   removed_q;
	logic                   rvld_s1;
	logic [POWER_WIDTH-1:0] hi_q;
	logic [POWER_WIDTH-1:0] median_q;
	logic                   done_q;

	logic [POWER_WIDTH-1:0] mem [WINDOW_DEPTH];
	logic [POWER_WIDTH-1:0] rd_data;
	logic [AW-1:0]          ra;
	logic [AW-1:0]          wa;
	logic [POWER_WIDTH-1:0] wd;
	logic                   we;

	logic                   skip;
	logic                   pass_end;
	logic [POWER_WIDTH-1:0] bub_lo;
	logic [POWER_WIDTH-1:0] bub_hi;
	logic [AW-1:0]          hi_idx;
	logic [AW-1:0]          lo_idx;
	logic [POWER_WIDTH:0]   mid_sum;

	always_comb begin
		skip     = rvld_s1 && !removed_q && (rd_data == old_q);
		pass_end = (rk_q == n_q) && !rvld_s1;
		if (rd_data < carry_q) begin
			bub_lo = rd_data;
			bub_hi = carry_q;
		end else begin
			bub_lo = carry_q;
			bub_hi = rd_data;
		end
		hi_idx  = AW'(m_q >> 1);
		lo_idx  = AW'((m_q >> 1) - 1'b1);
		mid_sum = {1'b0, hi_q} + {1'b0, rd_data};

		we = (state_q == ST_PASS) && ((rvld_s1 && !skip) || pass_end);
		wa = wi_q[AW-1:0];
		wd = pass_end ? carry_q : bub_lo;

		case (state_q)
			ST_PASS:   ra = rk_q[AW-1:0];
			ST_MED_LO: ra = lo_idx;
			default:   ra = hi_idx;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_data <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			n_q       <= '0;
			m_q       <= '0;
			rk_q      <= '0;
			wi_q      <= '0;
			carry_q   <= '0;
			old_q     <= '0;
			removed_q <= 1'b0;
			rvld_s1   <= 1'b0;
			hi_q      <= '0;
			median_q  <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= (state_q == ST_MED_SUM);
			case (state_q)
				ST_IDLE: begin
					if (ctrl.start) begin
						n_q       <= count;
						m_q       <= ctrl.remove ? count : count + 1'b1;
						old_q     <= old_value;
						carry_q   <= new_value;
						removed_q <= !ctrl.remove;
						rk_q      <= '0;
						wi_q      <= '0;
						rvld_s1   <= 1'b0;
						state_q   <= ST_PASS;
					end
				end
				ST_PASS: begin
					rvld_s1 <= (rk_q != n_q);
					if (rk_q != n_q) begin
						rk_q <= rk_q + 1'b1;
					end
					if (rvld_s1) begin
						if (skip) begin
							removed_q <= 1'b1;
						end else begin
							carry_q <= bub_hi;
							wi_q    <= wi_q + 1'b1;
						end
					end
					if (pass_end) begin
						state_q <= ST_MED_HI;
					end
				end
				ST_MED_HI: begin
					state_q <= ST_MED_LO;
				end
				ST_MED_LO: begin
					hi_q    <= rd_data;
					state_q <= ST_MED_SUM;
				end
				ST_MED_SUM: begin
					median_q <= m_q[0] ? hi_q : mid_sum[POWER_WIDTH:1];
					state_q  <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign median = median_q;

endmodule

`default_nettype wire

[sv/windowed_median_power_convergence_unit.sv]
// ----------------------------------------------------------------------------
// windowed_median_power_convergence_unit - power budget and median monitor
// Clamps power budgets, keeps a sliding window of power samples and reports
// the window median with a convergence flag, one result beat per input beat.
// ----------------------------------------------------------------------------
// Each input beat carries an optional budget and an optional power sample and
// yields exactly one result beat. A budget is clamped to [min_budget,
// max_budget] and a limit write is flagged when no budget is known or when it
// differs from the stored budget. Samples go into an arrival-order ring and
// into a sorted copy of the window, both single-port-write memories; the
// sorted copy is updated by one merge pass that reads one entry per cycle.
// A new beat is accepted only after the result of the last one is loaded
// into the output register. A beat without a sample skips the window update
// and reuses the median of the last update. The next beat is taken while a
// result still waits on the output register; a result that cannot be loaded
// because the output register is still full waits until that register is free.
// No memory clearing is needed after reset. Configuration writes are always
// taken and must only be issued while the unit is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_median_power_convergence_unit #(
	parameter int WINDOW_DEPTH = wmpc_pkg::WINDOW_DEPTH_DEF,
	parameter int POWER_WIDTH  = wmpc_pkg::POWER_WIDTH_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,

	// configuration write channel
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire [wmpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire [POWER_WIDTH-1:0]              cfg_data,

	// input stream
	input  wire                                s_tvalid,
	output logic                               s_tready,
	// budget_value, power_sample (zero padded to whole bytes)
	input  wire [((2*POWER_WIDTH+7)/8)*8-1:0]  s_tdata,
	// budget_valid, sample_valid
	input  wire [wmpc_pkg::IN_USER_W-1:0]      s_tuser,

	// result stream
	output logic                               m_tvalid,
	input  wire                                m_tready,
	// limit_value, median_power (zero padded to whole bytes)
	output logic [((2*POWER_WIDTH+7)/8)*8-1:0] m_tdata,
	// write_limit, report_valid, converged
	output logic [wmpc_pkg::OUT_USER_W-1:0]    m_tuser
);

	localparam int DATA_W = ((2*POWER_WIDTH+7)/8)*8;
	localparam int CW     = $clog2(WINDOW_DEPTH + 1);
	localparam int CMP_W  = (CW > wmpc_pkg::MIN_FILL_W) ? CW : wmpc_pkg::MIN_FILL_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SORT,
		ST_FINISH
	} state_t;

	state_t                               state_q;
	logic [CW-1:0]                        fill_q;
	logic [wmpc_pkg::MIN_FILL_W-1:0]      min_fill_q;
	logic [POWER_WIDTH-1:0]               sample_q;
	logic [CW-1:0]                        sort_n_q;
	wmpc_pkg::wmpc_sort_ctrl_t            sort_ctrl_q;
	logic                                 write_q;
	logic [POWER_WIDTH-1:0]               limit_q;
	logic                                 m_tvalid_q;
	logic [DATA_W-1:0]                    m_tdata_q;
	logic [wmpc_pkg::OUT_USER_W-1:0]      m_tuser_q;

	logic                                 cfg_we;
	logic                                 in_beat;
	logic                                 in_has_sample;
	logic [POWER_WIDTH-1:0]               in_budget;
	logic [POWER_WIDTH-1:0]               in_power;
	logic                                 bud_write;
	logic [POWER_WIDTH-1:0]               bud_limit;
	logic [POWER_WIDTH-1:0]               bud_stored;
	logic                                 bud_known;
	logic [POWER_WIDTH-1:0]               ring_old;
	logic                                 sort_done;
	logic [POWER_WIDTH-1:0]               sort_median;
	logic                                 report;
	logic                                 out_free;
	logic                                 out_load;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	assign s_tready      = (state_q == ST_IDLE);
	assign in_beat       = s_tvalid && s_tready;
	assign in_has_sample = s_tuser[wmpc_pkg::IN_SAMPLE_VLD];
	assign in_budget     = s_tdata[POWER_WIDTH-1:0];
	assign in_power      = s_tdata[2*POWER_WIDTH-1:POWER_WIDTH];

	// the window reports once its fill passes min_fill
	assign report   = CMP_W'(fill_q) > CMP_W'(min_fill_q);
	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = (state_q == ST_FINISH) && out_free;

	// budget is settled in the accept cycle; convergence later uses the
	// budget stored for this same beat
	wmpc_budget #(
		.POWER_WIDTH (POWER_WIDTH)
	) u_budget (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.update        (in_beat),
		.budget_valid  (s_tuser[wmpc_pkg::IN_BUDGET_VLD]),
		.budget_value  (in_budget),
		.write_limit   (bud_write),
		.limit_value   (bud_limit),
		.stored_budget (bud_stored),
		.budget_known  (bud_known)
	);

	// ring hands back the entry being overwritten in the cycle after the write,
	// which is the oldest sample once the window is full
	wmpc_ring #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.POWER_WIDTH  (POWER_WIDTH)
	) u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (in_beat && in_has_sample),
		.wr_data  (in_power),
		.old_data (ring_old)
	);

	wmpc_sorter #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.POWER_WIDTH  (POWER_WIDTH)
	) u_sorter (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (sort_ctrl_q),
		.count     (sort_n_q),
		.new_value (sample_q),
		.old_value (ring_old),
		.done      (sort_done),
		.median    (sort_median)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			min_fill_q  <= wmpc_pkg::MIN_FILL_RESET;
			sample_q    <= '0;
			sort_n_q    <= '0;
			sort_ctrl_q <= '0;
			write_q     <= 1'b0;
			limit_q     <= '0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
			m_tuser_q   <= '0;
		end else begin
			// pulse a window update for every accepted beat with a sample
			sort_ctrl_q.start <= in_beat && in_has_sample;

			if (cfg_we && (cfg_index == wmpc_pkg::CFG_MIN_FILL)) begin
				min_fill_q <= cfg_data[wmpc_pkg::MIN_FILL_W-1:0];
			end

			// load a new result beat when free, else hold it until taken
			m_tvalid_q <= out_load || (m_tvalid_q && !m_tready);

			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						write_q <= bud_write;
						limit_q <= bud_limit;
						if (in_has_sample) begin
							sample_q           <= in_power;
							sort_n_q           <= fill_q;
							sort_ctrl_q.remove <= (fill_q == CW'(WINDOW_DEPTH));
							if (fill_q != CW'(WINDOW_DEPTH)) begin
								fill_q <= fill_q + 1'b1;
							end
							state_q <= ST_SORT;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_SORT: begin
					if (sort_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					// hold until the output register is free
					if (out_load) begin
						m_tdata_q  <= DATA_W'({report ? sort_median : {POWER_WIDTH{1'b0}},
							limit_q});
						m_tuser_q[wmpc_pkg::OUT_WRITE_LIM] <= write_q;
						m_tuser_q[wmpc_pkg::OUT_REPORT]    <= report;
						m_tuser_q[wmpc_pkg::OUT_CONVERGED] <=
							report && bud_known && (sort_median <= bud_stored);
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire

[tb/sv/wmpc_tb_pkg.sv]
// ----------------------------------------------------------------------------
// wmpc_tb_pkg - result predictor and scoreboard for the median power unit
// Mirrors budget clamping, the sample ring and the window median, and checks
// each result beat against the oldest predicted report.
// ----------------------------------------------------------------------------
`default_nettype none

package wmpc_tb_pkg;

	import wmpc_pkg::*;

	localparam int PW     = POWER_WIDTH_DEF;
	localparam int DEPTH  = WINDOW_DEPTH_DEF;
	localparam int DATA_W = ((2*PW+7)/8)*8;

	typedef struct packed {
		logic          write_limit;
		logic [PW-1:0] limit_value;
		logic          report_valid;
		logic [PW-1:0] median_power;
		logic          converged;
	} power_report_t;

	class median_scoreboard;
		logic [PW-1:0]         min_budget;
		logic [PW-1:0]         max_budget;
		logic [MIN_FILL_W-1:0] min_fill;
		logic [PW-1:0]         ring [DEPTH];
		int unsigned           ring_ptr;
		int unsigned           ring_fill;
		logic [PW-1:0]         budget;
		logic                  budget_known;
		power_report_t         report_q [$];
		int unsigned           mismatches;
		int unsigned           beats_seen;

		function new();
			min_budget   = '0;
			max_budget   = '1;
			min_fill     = MIN_FILL_RESET;
			ring_ptr     = 0;
			ring_fill    = 0;
			budget       = '0;
			budget_known = 1'b0;
			mismatches   = 0;
			beats_seen   = 0;
			foreach (ring[i]) ring[i] = '0;
		endfunction

		function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [PW-1:0] data);
			case (idx)
				CFG_MIN_BUDGET: min_budget = data;
				CFG_MAX_BUDGET: max_budget = data;
				CFG_MIN_FILL:   min_fill   = data[MIN_FILL_W-1:0];
				default: ;
			endcase
		endfunction

		// sort the filled part of the ring and take the middle (mean of two when even)
		function logic [PW-1:0] window_median();
			logic [PW-1:0] sorted [DEPTH];
			logic [PW-1:0] tmp;
			logic [PW:0]   pair_sum;
			int            n;
			n = ring_fill;
			for (int i = 0; i < n; i++) sorted[i] = ring[i];
			for (int i = 0; i < n - 1; i++) begin
				for (int j = 0; j < n - 1 - i; j++) begin
					if (sorted[j] > sorted[j+1]) begin
						tmp         = sorted[j];
						sorted[j]   = sorted[j+1];
						sorted[j+1] = tmp;
					end
				end
			end
			if (n % 2 == 1) return sorted[n/2];
			pair_sum = {1'b0, sorted[n/2-1]} + {1'b0, sorted[n/2]};
			return pair_sum[PW:1];
		endfunction

		function void note_beat(logic bv, logic [PW-1:0] bval, logic sv, logic [PW-1:0] sval);
			power_report_t r;
			logic [PW-1:0] clamped;
			r = '0;
			if (bv) begin
				if (bval < min_budget)      clamped = min_budget;
				else if (bval > max_budget) clamped = max_budget;
				else                        clamped = bval;
				if (!budget_known || budget != clamped) begin
					r.write_limit = 1'b1;
					r.limit_value = clamped;
				end
				budget       = clamped;
				budget_known = 1'b1;
			end else begin
				budget       = '0;
				budget_known = 1'b0;
			end
			if (sv) begin
				ring[ring_ptr] = sval;
				ring_ptr = (ring_ptr + 1) % DEPTH;
				if (ring_fill < DEPTH) ring_fill++;
			end
			if (ring_fill > min_fill) begin
				r.report_valid = 1'b1;
				r.median_power = window_median();
				r.converged    = budget_known && (r.median_power <= budget);
			end
			report_q.push_back(r);
		endfunction

		task report_mismatch(string what, logic [PW-1:0] want, logic [PW-1:0] seen);
			mismatches++;
			$display("MISMATCH beat %0d %s: expected 0x%0h, got 0x%0h",
				beats_seen, what, want, seen);
		endtask

		task check_beat(logic [OUT_USER_W-1:0] user, logic [DATA_W-1:0] data);
			power_report_t want;
			power_report_t got;
			got.write_limit  = user[OUT_WRITE_LIM];
			got.report_valid = user[OUT_REPORT];
			got.converged    = user[OUT_CONVERGED];
			got.limit_value  = data[PW-1:0];
			got.median_power = data[2*PW-1:PW];
			beats_seen++;
			if (report_q.size() == 0) begin
				report_mismatch("result with nothing outstanding", '0, got.median_power);
				return;
			end
			want = report_q.pop_front();
			if (got.write_limit != want.write_limit)
				report_mismatch("write_limit", PW'(want.write_limit), PW'(got.write_limit));
			if (got.limit_value != want.limit_value)
				report_mismatch("limit_value", want.limit_value, got.limit_value);
			if (got.report_valid != want.report_valid)
				report_mismatch("report_valid", PW'(want.report_valid),
					PW'(got.report_valid));
			if (got.median_power != want.median_power)
				report_mismatch("median_power", want.median_power, got.median_power);
			if (got.converged != want.converged)
				report_mismatch("converged", PW'(want.converged), PW'(got.converged));
		endtask

		function int unsigned outstanding();
			return report_q.size();
		endfunction
	endclass

endpackage

`default_nettype wire

[tb/sv/windowed_median_power_convergence_unit_tb.sv]
// ----------------------------------------------------------------------------
// windowed_median_power_convergence_unit_tb - stream-level test of the unit
// Drives budget/sample beats with random gaps and output back-pressure,
// predicts every result beat and compares it field by field; sweeps the
// budget bounds and fill threshold between bursts, inverted bounds included.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_median_power_convergence_unit_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import wmpc_pkg::*;
	import wmpc_tb_pkg::*;

	// typical sample region; budgets drawn here straddle the window median
	localparam logic [PW-1:0] REGION_BASE = 24'h400000;
	localparam int unsigned   REGION_SPAN = 32'h3FFFFF;
	// long output hold-off: enough for the unit to back up into its input
	localparam int unsigned   HOLD_OFF_CYCLES = 400;
	// settle time after the last result: one full-window update plus margin
	localparam int unsigned   SETTLE_CYCLES = 40;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [PW-1:0]          cfg_data  = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [DATA_W-1:0]      s_tdata   = '0;  // budget_value, power_sample
	logic [IN_USER_W-1:0]   s_tuser   = '0;  // budget_valid, sample_valid
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [DATA_W-1:0]      m_tdata;         // limit_value, median_power
	logic [OUT_USER_W-1:0]  m_tuser;         // write_limit, report_valid, converged

	median_scoreboard sb;
	int unsigned      beat_gap_pct  = 0;   // chance the sender idles before a beat
	int unsigned      ready_gap_pct = 0;   // chance the receiver drops tready
	bit               stall_request = 1'b0;
	logic [PW-1:0]    last_budget   = '0;

	windowed_median_power_convergence_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Result side: check every accepted beat, then pick the next tready.
	// A stall request turns into a long hold-off counted right here, while
	// the sender keeps offering beats.
	initial begin : result_sink
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) sb.check_beat(m_tuser, m_tdata);
			if (stall_request) begin
				hold_left     = HOLD_OFF_CYCLES;
				stall_request = 1'b0;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= ready_gap_pct);
			end
		end
	end

	// Offer one beat, idling first at random; return once it is taken.
	// tvalid stays high into the next beat unless that one idles first.
	task automatic send_beat(logic bv, logic [PW-1:0] bval, logic sv, logic [PW-1:0] sval);
		logic [DATA_W-1:0]    d;
		logic [IN_USER_W-1:0] u;
		d = '0;
		d[PW-1:0]    = bval;
		d[2*PW-1:PW] = sval;
		u = '0;
		u[IN_BUDGET_VLD] = bv;
		u[IN_SAMPLE_VLD] = sv;
		while ($urandom_range(0, 99) < beat_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tuser  <= u;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_beat(bv, bval, sv, sval);
	endtask

	// Drop tvalid, wait for every predicted report, then let the last
	// window update finish so the unit is idle for register writes.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register beat; valid is held by the caller between beats.
	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [PW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_register(idx, data);
	endtask

	// Write all three registers back to back. The fill threshold carries
	// random upper data bits, which the unit must ignore.
	task automatic load_settings(logic [PW-1:0] lo, logic [PW-1:0] hi,
			logic [MIN_FILL_W-1:0] fill);
		logic [PW-1:0] fill_word;
		fill_word = PW'($urandom());
		fill_word[MIN_FILL_W-1:0] = fill;
		write_reg(CFG_MIN_BUDGET, lo);
		write_reg(CFG_MAX_BUDGET, hi);
		write_reg(CFG_MIN_FILL, fill_word);
		cfg_valid <= 1'b0;
	endtask

	// Mostly valid budgets, often repeated so that no limit write is due,
	// sometimes absent; mostly valid samples from the typical region with
	// extremes and full-range values mixed in.
	task automatic random_beats(int unsigned count);
		logic          bv;
		logic          sv;
		logic [PW-1:0] bval;
		logic [PW-1:0] sval;
		int unsigned   pick;
		repeat (count) begin
			pick = $urandom_range(0, 9);
			bv   = (pick != 0);
			case (pick)
				1, 2, 3: bval = last_budget;
				4:       bval = $urandom_range(0, 1) ? '1 : '0;
				0, 5:    bval = PW'($urandom());
				default: bval = PW'(REGION_BASE + $urandom_range(0, REGION_SPAN));
			endcase
			if (bv) last_budget = bval;
			sv   = ($urandom_range(0, 99) < 80);
			pick = $urandom_range(0, 9);
			case (pick)
				0:       sval = $urandom_range(0, 1) ? '1 : '0;
				1, 2:    sval = PW'($urandom());
				default: sval = PW'(REGION_BASE + $urandom_range(0, REGION_SPAN));
			endcase
			send_beat(bv, bval, sv, sval);
		end
	endtask

	initial begin : stimulus
		logic [PW-1:0] lo;
		logic [PW-1:0] hi;
		sb = new();
		beat_gap_pct  = 20;
		ready_gap_pct = 47;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings, window under the fill threshold: no reports.
		// First budget always writes, a repeat does not, a missing one
		// forgets the stored budget.
		send_beat(1'b1, 24'h000000, 1'b1, 24'h000000);
		send_beat(1'b1, 24'h000000, 1'b1, 24'hFFFFFF);
		send_beat(1'b1, 24'hFFFFFF, 1'b1, 24'hFFFFFF);
		send_beat(1'b0, 24'hFFFFFF, 1'b1, 24'h000000);
		send_beat(1'b0, 24'h000000, 1'b0, 24'h000000);
		settle();

		// Low threshold: even and odd medians, convergence at equality,
		// unknown budget, then a full window that wraps.
		load_settings(24'h000000, 24'hFFFFFF, 4'd2);
		send_beat(1'b1, 24'h400000, 1'b0, 24'hABCDEF);
		send_beat(1'b1, 24'h7FFFFF, 1'b1, 24'h400000);
		repeat (9) send_beat(1'b1, 24'h400000, 1'b1, 24'h400000);
		send_beat(1'b0, 24'h400000, 1'b1, 24'h400000);
		send_beat(1'b1, 24'h3FFFFF, 1'b1, 24'hFFFFFF);
		send_beat(1'b1, 24'hFFFFFF, 1'b1, 24'h000001);
		send_beat(1'b1, 24'hFFFFFF, 1'b1, 24'h000002);
		settle();

		// Inverted bounds: below the minimum gives the minimum, anything
		// else above the maximum gives the maximum.
		load_settings(24'h800000, 24'h100000, 4'd15);
		send_beat(1'b1, 24'h000000, 1'b0, 24'h000000);
		send_beat(1'b1, 24'h800000, 1'b0, 24'h000000);
		send_beat(1'b1, 24'hFFFFFF, 1'b1, 24'h5A5A5A);
		send_beat(1'b1, 24'h7FFFFF, 1'b1, 24'hA5A5A5);
		settle();

		// Sender idles less than the receiver; the first burst also
		// carries the long output hold-off.
		load_settings(24'h000000, 24'hFFFFFF, 4'd0);
		stall_request = 1'b1;
		random_beats(230);
		settle();
		load_settings(24'h500000, 24'h600000, 4'd7);
		random_beats(230);
		settle();
		load_settings(24'h580000, 24'h580000, 4'd15);
		random_beats(230);
		settle();

		// Sender idles more often than the receiver.
		beat_gap_pct  = 47;
		ready_gap_pct = 20;
		lo = PW'($urandom_range(0, 32'h5FFFFF));
		hi = PW'(lo + $urandom_range(0, 32'h3FFFFF));
		load_settings(lo, hi, MIN_FILL_W'($urandom_range(0, 15)));
		random_beats(230);
		settle();
		load_settings(24'h700000, 24'h480000, 4'd3);
		random_beats(230);
		settle();
		load_settings(24'hFFFFFF, 24'h000000, 4'd1);
		random_beats(230);
		settle();

		// No idling on either side: back-to-back beats, plus a second
		// hold-off at full input rate.
		beat_gap_pct  = 0;
		ready_gap_pct = 0;
		lo = PW'($urandom_range(0, 32'h7FFFFF));
		hi = PW'(lo + $urandom_range(0, 32'h7FFFFF));
		load_settings(lo, hi, 4'd15);
		stall_request = 1'b1;
		random_beats(230);
		settle();
		load_settings(24'h000000, 24'hFFFFFF, MIN_FILL_W'($urandom_range(0, 15)));
		random_beats(230);
		settle();

		if (sb.mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Hard stop, far beyond the slowest correct run.
	initial begin : watchdog
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire

[filelist.f]
sv/wmpc_pkg.sv
sv/wmpc_budget.sv
sv/wmpc_ring.sv
sv/wmpc_sorter.sv
sv/windowed_median_power_convergence_unit.sv
tb/sv/wmpc_tb_pkg.sv
tb/sv/windowed_median_power_convergence_unit_tb.sv
